// File: design/gc3_pkg.sv
// shared constants, register indexes and coefficient helper for the 3x3 grid convolution
// depends on nothing; used by grid_convolution_3x3, gc3_front and gc3_back
`default_nettype none
package gc3_pkg;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int KERNEL_SIZE     = 3;
    localparam int TAPS            = KERNEL_SIZE * KERNEL_SIZE;
    localparam int COEF_BITS       = 16;
    localparam int ROW_BITS        = 48;
    localparam int FRAC_BITS       = 8;
    localparam int SUM_BITS        = 20;
    localparam int HEIGHT_BITS     = 16;
    localparam int CFG_DATA_BITS   = 48;
    localparam int CFG_IDX_BITS    = 3;
    localparam int GRID_W_BITS     = 11;

    localparam logic [ROW_BITS-1:0] RST_COEF_TOP = '0;
    localparam logic [ROW_BITS-1:0] RST_COEF_MID = ROW_BITS'(256);
    localparam logic [ROW_BITS-1:0] RST_COEF_BOT = '0;
    localparam int RST_WIDTH  = 1024;
    localparam int RST_HEIGHT = 1024;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COEF_TOP = 3'd0,
        REG_COEF_MID = 3'd1,
        REG_COEF_BOT = 3'd2,
        REG_NORMAL   = 3'd3,
        REG_WIDTH    = 3'd4,
        REG_HEIGHT   = 3'd5
    } t_reg_idx;

    typedef logic [KERNEL_SIZE-1:0][ROW_BITS-1:0] t_coef_rows;

    // signed coefficient of mask row r, column k
    function automatic logic signed [COEF_BITS-1:0] coef_at(t_coef_rows rows, int r, int k);
        logic [ROW_BITS-1:0] word;
        word = rows[r];
        return $signed(word[COEF_BITS*k +: COEF_BITS]);
    endfunction

endpackage
`default_nettype wire

// File: design/grid_convolution_3x3.sv
// 3x3 zero-padded grid convolution: config registers, front end, queue and back end
// input: o_stall is raised while the front end handles a sample, and held while the queue is full
// back end: takes one cell at a time from the queue, through the restoring divider when
// normalising by the coefficient sum
// reset: synchronous active low; clears position, window and handshakes, loads a mask with
// 256 at the middle row, left tap; the line store is not cleared and needs no clearing pass
`default_nettype none
module grid_convolution_3x3 #(
    parameter int MAX_WIDTH   = gc3_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = gc3_pkg::DEF_SAMPLE_BITS,
    localparam int CB = $clog2(MAX_WIDTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_is_flush,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_filtered,
    output logic [gc3_pkg::HEIGHT_BITS-1:0]    o_out_row,
    output logic [CB-1:0]                      o_out_col,
    output logic                               o_last_cell,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [gc3_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [gc3_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import gc3_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int TB = WB + HEIGHT_BITS;
    localparam int JW = 1 + CB + HEIGHT_BITS + TAPS * SAMPLE_BITS;
    localparam int W0 = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;

    t_coef_rows                 r_coef;
    logic                       r_norm;
    logic [WB-1:0]              r_width;
    logic [HEIGHT_BITS-1:0]     r_height;
    logic [TB-1:0]              r_total;
    logic signed [SUM_BITS-1:0] r_coef_sum;
    logic signed [SUM_BITS-1:0] n_coef_sum;

    logic                       cfg_wr, restart;
    logic [GRID_W_BITS-1:0]     w_raw;
    logic [WB-1:0]              w_new;
    logic [HEIGHT_BITS-1:0]     h_new;
    logic                       push, full, pop, empty;
    logic [JW-1:0]              job_in, job_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign restart     = cfg_wr && (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT);

    // clamp the geometry writes
    always_comb begin
        w_raw = i_cfg_data[GRID_W_BITS-1:0];
        if (w_raw == '0)                  w_new = WB'(1);
        else if (int'(w_raw) > MAX_WIDTH) w_new = WB'(MAX_WIDTH);
        else                              w_new = WB'(w_raw);
        h_new = i_cfg_data[HEIGHT_BITS-1:0];
        if (h_new == '0) h_new = HEIGHT_BITS'(1);
    end

    // coefficient sum
    always_comb begin
        n_coef_sum = '0;
        for (int r = 0; r < KERNEL_SIZE; r++)
            for (int k = 0; k < KERNEL_SIZE; k++)
                n_coef_sum = n_coef_sum + SUM_BITS'(coef_at(r_coef, r, k));
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0]  <= RST_COEF_TOP;
            r_coef[1]  <= RST_COEF_MID;
            r_coef[2]  <= RST_COEF_BOT;
            r_norm     <= 1'b0;
            r_width    <= WB'(W0);
            r_height   <= HEIGHT_BITS'(RST_HEIGHT);
            r_total    <= TB'(W0 * RST_HEIGHT);
            r_coef_sum <= SUM_BITS'(256);
        end else begin
            r_total    <= TB'(r_width) * TB'(r_height);
            r_coef_sum <= n_coef_sum;
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    REG_COEF_TOP: r_coef[0] <= i_cfg_data[ROW_BITS-1:0];
                    REG_COEF_MID: r_coef[1] <= i_cfg_data[ROW_BITS-1:0];
                    REG_COEF_BOT: r_coef[2] <= i_cfg_data[ROW_BITS-1:0];
                    REG_NORMAL:   r_norm    <= i_cfg_data[0];
                    REG_WIDTH:    r_width   <= w_new;
                    REG_HEIGHT:   r_height  <= h_new;
                    default: ;
                endcase
            end
        end
    end

    gc3_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_sample   (i_sample),
        .i_is_flush (i_is_flush),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_total    (r_total),
        .i_restart  (restart),
        .o_push     (push),
        .o_job      (job_in),
        .i_full     (full)
    );

    gc3_queue #(
        .DW (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (empty)
    );

    gc3_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_coef      (r_coef),
        .i_coef_sum  (r_coef_sum),
        .i_norm      (r_norm),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_filtered  (o_filtered),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last_cell (o_last_cell)
    );
endmodule
`default_nettype wire

// File: design/gc3_queue.sv
// two-entry queue that decouples the window front end from the arithmetic back end
// depends on nothing
`default_nettype none
module gc3_queue #(
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic [DW-1:0]      o_data,
    output logic               o_empty
);
    logic [DW-1:0] r_data [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_data[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_data[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

// File: design/gc3_front.sv
// front end: takes input transactions, tracks grid position, keeps line stores and window
// depends on gc3_pkg; feeds masked 3x3 windows to gc3_queue
`default_nettype none
module gc3_front #(
    parameter int MAX_WIDTH   = gc3_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = gc3_pkg::DEF_SAMPLE_BITS,
    localparam int CB = $clog2(MAX_WIDTH),
    localparam int WB = $clog2(MAX_WIDTH + 1),
    localparam int TB = WB + gc3_pkg::HEIGHT_BITS,
    localparam int JW = 1 + CB + gc3_pkg::HEIGHT_BITS + gc3_pkg::TAPS * SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_is_flush,
    input  wire logic [WB-1:0]                 i_width,
    input  wire logic [gc3_pkg::HEIGHT_BITS-1:0] i_height,
    input  wire logic [TB-1:0]                 i_total,
    input  wire logic                          i_restart,
    output logic                               o_push,
    output logic [JW-1:0]                      o_job,
    input  wire logic                          i_full
);
    import gc3_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_PROC = 2'b10
    } t_fstate;

    t_fstate r_state;
    logic [SAMPLE_BITS-1:0]   r_x;
    logic [16:0]              r_ir;
    logic [CB-1:0]            r_ic;
    logic [TB-1:0]            r_cnt;
    logic [SAMPLE_BITS-1:0]   r_win1 [KERNEL_SIZE];
    logic [SAMPLE_BITS-1:0]   r_win2 [KERNEL_SIZE];
    logic [2*SAMPLE_BITS-1:0] r_mem [MAX_WIDTH];
    logic [2*SAMPLE_BITS-1:0] r_rd;

    logic [SAMPLE_BITS-1:0]   col [KERNEL_SIZE];
    logic signed [17:0]       crow;
    logic signed [17:0]       gr;
    logic signed [17:0]       h_s;
    logic [KERNEL_SIZE-1:0]   gr_ok;
    logic                     left_ok, right_ok, emit, go, last, col_wrap;
    logic [CB-1:0]            ccol;
    logic [WB-1:0]            w_m1;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] taps;

    assign o_stall = (r_state != F_IDLE);

    // neighbourhood columns and output position for the item in hand
    always_comb begin
        col[0]   = r_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
        col[1]   = r_rd[SAMPLE_BITS-1:0];
        col[2]   = r_x;
        h_s      = $signed({2'b00, i_height});
        w_m1     = i_width - WB'(1);
        if (r_ic != '0) begin
            crow     = $signed({1'b0, r_ir}) - 18'sd1;
            ccol     = r_ic - CB'(1);
            left_ok  = (r_ic != CB'(1));
            right_ok = 1'b1;
        end else begin
            crow     = $signed({1'b0, r_ir}) - 18'sd2;
            ccol     = w_m1[CB-1:0];
            left_ok  = (i_width != WB'(1));
            right_ok = 1'b0;
        end
        emit = (crow >= 18'sd0) && (crow < h_s);
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            gr       = crow - 18'sd1 + 18'(r);
            gr_ok[r] = (gr >= 18'sd0) && (gr < h_s);
        end
        // masked taps: out-of-grid neighbours add nothing
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            taps[r*KERNEL_SIZE + 0] = (gr_ok[r] && left_ok)  ? r_win1[r] : '0;
            taps[r*KERNEL_SIZE + 1] = gr_ok[r]               ? r_win2[r] : '0;
            taps[r*KERNEL_SIZE + 2] = (gr_ok[r] && right_ok) ? col[r]    : '0;
        end
        last     = emit && ((r_cnt + TB'(1)) == i_total);
        go       = (r_state == F_PROC) && (!emit || !i_full);
        col_wrap = ({1'b0, r_ic} + (CB+1)'(1)) >= (CB+1)'(i_width);
    end

    assign o_push = (r_state == F_PROC) && emit && !i_full;
    assign o_job  = {last, ccol, crow[15:0], taps};

    // control, position and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_ir    <= '0;
            r_ic    <= '0;
            r_cnt   <= '0;
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                r_win1[r] <= '0;
                r_win2[r] <= '0;
            end
        end else if (i_restart) begin
            r_ir  <= '0;
            r_ic  <= '0;
            r_cnt <= '0;
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                r_win1[r] <= '0;
                r_win2[r] <= '0;
            end
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) r_state <= F_PROC;
                end
                F_PROC: begin
                    if (go) begin
                        r_state <= F_IDLE;
                        if (last) begin
                            r_ir  <= '0;
                            r_ic  <= '0;
                            r_cnt <= '0;
                            for (int r = 0; r < KERNEL_SIZE; r++) begin
                                r_win1[r] <= '0;
                                r_win2[r] <= '0;
                            end
                        end else begin
                            for (int r = 0; r < KERNEL_SIZE; r++) begin
                                r_win1[r] <= r_win2[r];
                                r_win2[r] <= col[r];
                            end
                            if (emit) r_cnt <= r_cnt + TB'(1);
                            if (col_wrap) begin
                                r_ic <= '0;
                                r_ir <= r_ir + 17'd1;
                            end else begin
                                r_ic <= r_ic + CB'(1);
                            end
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // sample capture, padding past the grid reads as zero
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_x <= (i_is_flush || (r_ir >= {1'b0, i_height})) ? '0 : i_sample;
        end
    end

    // line store: both earlier rows in one entry per column
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) r_rd <= r_mem[r_ic];
        if (go) r_mem[r_ic] <= {r_rd[SAMPLE_BITS-1:0], r_x};
    end
endmodule
`default_nettype wire

// File: design/gc3_back.sv
// back end: multiply-accumulate over the window, rounded division, saturation, output register
// depends on gc3_pkg; takes jobs from gc3_queue
`default_nettype none
module gc3_back #(
    parameter int MAX_WIDTH   = gc3_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = gc3_pkg::DEF_SAMPLE_BITS,
    localparam int CB = $clog2(MAX_WIDTH),
    localparam int JW = 1 + CB + gc3_pkg::HEIGHT_BITS + gc3_pkg::TAPS * SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [JW-1:0]                 i_job,
    input  wire logic                          i_empty,
    output logic                               o_pop,
    input  wire gc3_pkg::t_coef_rows           i_coef,
    input  wire logic signed [gc3_pkg::SUM_BITS-1:0] i_coef_sum,
    input  wire logic                          i_norm,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_filtered,
    output logic [gc3_pkg::HEIGHT_BITS-1:0]    o_out_row,
    output logic [CB-1:0]                      o_out_col,
    output logic                               o_last_cell
);
    import gc3_pkg::*;

    localparam int PB = SAMPLE_BITS + COEF_BITS;
    localparam int AW = PB + 4;
    localparam int NB = AW + 1;
    localparam int DB = SUM_BITS + 1;
    localparam int KB = $clog2(NB + 1);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MUL  = 5'b00010,
        B_SUM  = 5'b00100,
        B_DIV  = 5'b01000,
        B_DONE = 5'b10000
    } t_bstate;

    t_bstate r_state;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] r_taps;
    logic [HEIGHT_BITS-1:0] r_row;
    logic [CB-1:0]          r_col;
    logic                   r_last;
    logic signed [PB-1:0]   r_prod [TAPS];
    logic [NB-1:0]          r_num;
    logic [DB-1:0]          r_den;
    logic [DB-1:0]          r_rem;
    logic                   r_neg;
    logic [KB-1:0]          r_k;
    logic                   r_ovalid;

    logic signed [AW-1:0]       acc;
    logic [AW-1:0]              n_abs;
    logic                       norm_div;
    logic signed [SUM_BITS-1:0] den;
    logic [SUM_BITS-1:0]        d_abs;
    logic [DB:0]                rem_sh;
    logic                       qbit;
    logic [DB-1:0]              rem_nx;
    logic [NB-1:0]              q_neg;
    logic [SAMPLE_BITS-1:0]     res;
    logic                       load;

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign o_valid = r_ovalid;
    assign load    = (r_state == B_DONE) && (!r_ovalid || !i_stall);

    // accumulation and operands of the division
    always_comb begin
        acc = '0;
        for (int i = 0; i < TAPS; i++) acc = acc + AW'(r_prod[i]);
        n_abs    = acc[AW-1] ? AW'(-acc) : AW'(acc);
        norm_div = i_norm && (i_coef_sum != '0);
        den      = norm_div ? i_coef_sum : SUM_BITS'(1 << FRAC_BITS);
        d_abs    = den[SUM_BITS-1] ? SUM_BITS'(-den) : SUM_BITS'(den);
    end

    // one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_num[NB-1]};
        qbit   = (rem_sh >= {1'b0, r_den});
        rem_nx = qbit ? DB'(rem_sh - {1'b0, r_den}) : rem_sh[DB-1:0];
    end

    // sign and saturation of the quotient
    always_comb begin
        q_neg = ~r_num + NB'(1);
        if (r_neg) begin
            if (r_num > NB'(1) << (SAMPLE_BITS - 1)) res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            else                                     res = q_neg[SAMPLE_BITS-1:0];
        end else begin
            if (r_num > (NB'(1) << (SAMPLE_BITS - 1)) - NB'(1))
                res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            else
                res = r_num[SAMPLE_BITS-1:0];
        end
    end

    // sequencer, the fixed scale skips the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: if (!i_empty) r_state <= B_MUL;
                B_MUL:  r_state <= B_SUM;
                B_SUM:  r_state <= norm_div ? B_DIV : B_DONE;
                B_DIV:  if (r_k == KB'(1)) r_state <= B_DONE;
                B_DONE: if (load) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_last, r_col, r_row, r_taps} <= i_job;
        end
        if (r_state == B_MUL) begin
            for (int i = 0; i < TAPS; i++) begin
                r_prod[i] <= $signed(r_taps[i]) * coef_at(i_coef, i / KERNEL_SIZE,
                                                          i % KERNEL_SIZE);
            end
        end
        if (r_state == B_SUM) begin
            if (norm_div) r_num <= {n_abs, 1'b0} + NB'(d_abs);
            else          r_num <= NB'((n_abs + AW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
            r_den <= {d_abs, 1'b0};
            r_rem <= '0;
            r_neg <= acc[AW-1] ^ den[SUM_BITS-1];
            r_k   <= KB'(NB);
        end
        if (r_state == B_DIV) begin
            r_rem <= rem_nx;
            r_num <= {r_num[NB-2:0], qbit};
            r_k   <= r_k - KB'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_filtered  <= $signed(res);
            o_out_row   <= r_row;
            o_out_col   <= r_col;
            o_last_cell <= r_last;
        end
    end
endmodule
`default_nettype wire
